// ----- hdl/ltc_pkg.sv -----
// Shared types and constants for the LRU tile cache lookup block.
package ltc_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int COORD_BITS_DEF = 16;
  localparam int CAP_BITS       = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic clear;
    logic proc;
  } scan_ctrl_t;

  typedef struct packed {
    logic found;
    logic free_found;
    logic lru_any;
  } scan_stat_t;

endpackage

// ----- hdl/ltc_tag_ram.sv -----
// Tag and recency memory: one write port, one registered read port.
module ltc_tag_ram import ltc_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int WIDTH = 2 * COORD_BITS_DEF + $clog2(SLOTS_DEF),
  localparam int IW = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [IW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/ltc_scan.sv -----
// Scan stage: applies the previous item's recency update to each entry read
// back, writes it back, and tracks match, free slot and LRU candidate.
module ltc_scan import ltc_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IW = $clog2(SLOTS),
  localparam int LW = $clog2(SLOTS + 1),
  localparam int DW = 2 * COORD_BITS + IW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  scan_ctrl_t            ctrl,
  input  logic [IW-1:0]         idx,
  input  logic                  entry_vld,
  input  logic [DW-1:0]         rd_data,
  input  logic [COORD_BITS-1:0] req_x,
  input  logic [COORD_BITS-1:0] req_y,
  input  logic                  pend_on,
  input  logic [IW-1:0]         pend_slot,
  input  logic [LW-1:0]         pend_limit,
  input  logic [COORD_BITS-1:0] pend_x,
  input  logic [COORD_BITS-1:0] pend_y,
  output logic                  wr_en,
  output logic [IW-1:0]         wr_addr,
  output logic [DW-1:0]         wr_data,
  output scan_stat_t            stat,
  output logic [IW-1:0]         hit_idx,
  output logic [IW-1:0]         hit_rank,
  output logic [IW-1:0]         free_idx,
  output logic [IW-1:0]         lru_idx,
  output logic [COORD_BITS-1:0] lru_x,
  output logic [COORD_BITS-1:0] lru_y
);

  logic [COORD_BITS-1:0] rd_x, rd_y, upd_x, upd_y;
  logic [IW-1:0]         rd_rank, upd_rank, lru_rank;
  logic                  match, older;

  assign rd_x    = rd_data[DW-1 -: COORD_BITS];
  assign rd_y    = rd_data[IW +: COORD_BITS];
  assign rd_rank = rd_data[IW-1:0];

  // The pending update belongs to the item before this one.
  always_comb begin
    upd_x    = rd_x;
    upd_y    = rd_y;
    upd_rank = rd_rank;
    if (pend_on) begin
      if (pend_slot == idx) begin
        upd_x    = pend_x;
        upd_y    = pend_y;
        upd_rank = '0;
      end else if (entry_vld && ({1'b0, rd_rank} < pend_limit)) begin
        upd_rank = rd_rank + IW'(1);
      end
    end
    match = entry_vld && (upd_x == req_x) && (upd_y == req_y);
    older = !stat.lru_any || (upd_rank > lru_rank);
  end

  assign wr_en   = ctrl.proc;
  assign wr_addr = idx;
  assign wr_data = {upd_x, upd_y, upd_rank};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else if (ctrl.clear) begin
      stat <= '0;
    end else if (ctrl.proc) begin
      if (match) begin
        stat.found <= 1'b1;
      end
      if (!entry_vld) begin
        stat.free_found <= 1'b1;
      end
      if (entry_vld) begin
        stat.lru_any <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.proc) begin
      if (match && !stat.found) begin
        hit_idx  <= idx;
        hit_rank <= upd_rank;
      end
      if (!entry_vld && !stat.free_found) begin
        free_idx <= idx;
      end
      if (entry_vld && older) begin
        lru_idx  <= idx;
        lru_rank <= upd_rank;
        lru_x    <= upd_x;
        lru_y    <= upd_y;
      end
    end
  end

endmodule

// ----- hdl/lru_tile_cache_lookup.sv -----
// Top level of the LRU tile cache lookup: control, valid bits and results.
//
// A lookup is started by start while busy is low. The tag memory is walked
// one entry per cycle through its single read port, then the read pipeline
// drains, the decide state picks the result, and the idle state with busy
// low takes the next item. The result appears on the result ports for
// exactly one cycle with done high, in that first cycle with busy low; it is
// not held, so the receiver must take it then. The recency update of an item
// is written back while the next item walks the memory.
// capacity_in_use may be written through cfg_we/cfg_data only while idle.
module lru_tile_cache_lookup import ltc_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IW = $clog2(SLOTS),
  localparam int LW = $clog2(SLOTS + 1),
  localparam int DW = 2 * COORD_BITS + IW,
  localparam int WW = (LW > CAP_BITS) ? LW : CAP_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] tile_x,
  input  logic [COORD_BITS-1:0] tile_y,
  input  logic                  cfg_we,
  input  logic [CAP_BITS-1:0]   cfg_data,
  output logic                  done,
  output logic                  hit,
  output logic [IW-1:0]         slot,
  output logic                  evicted,
  output logic [COORD_BITS-1:0] evicted_x,
  output logic [COORD_BITS-1:0] evicted_y
);

  state_t state, state_next;

  logic [CAP_BITS-1:0]   capacity_in_use;
  logic [IW-1:0]         rd_idx;
  logic                  rd_last;
  logic                  dv;
  logic [IW-1:0]         di;
  logic [COORD_BITS-1:0] req_x, req_y;
  logic [SLOTS-1:0]      valid;
  logic [LW-1:0]         entries_used;
  logic                  pend_on;
  logic [IW-1:0]         pend_slot;
  logic [LW-1:0]         pend_limit;
  logic [COORD_BITS-1:0] pend_x, pend_y;

  logic       accept, issue, decide, scan_done;
  scan_ctrl_t ctrl;
  scan_stat_t stat;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [DW-1:0] wr_data, rd_data;

  logic [IW-1:0]         hit_idx, hit_rank, free_idx, lru_idx;
  logic [COORD_BITS-1:0] lru_x, lru_y;

  logic [WW-1:0] cap_eff;
  logic          room;

  ltc_tag_ram #(
    .SLOTS (SLOTS),
    .WIDTH (DW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (issue),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  ltc_scan #(
    .SLOTS      (SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .idx        (di),
    .entry_vld  (valid[di]),
    .rd_data    (rd_data),
    .req_x      (req_x),
    .req_y      (req_y),
    .pend_on    (pend_on),
    .pend_slot  (pend_slot),
    .pend_limit (pend_limit),
    .pend_x     (pend_x),
    .pend_y     (pend_y),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .stat       (stat),
    .hit_idx    (hit_idx),
    .hit_rank   (hit_rank),
    .free_idx   (free_idx),
    .lru_idx    (lru_idx),
    .lru_x      (lru_x),
    .lru_y      (lru_y)
  );

  assign scan_done = dv && (di == IW'(SLOTS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_SCAN;
      ST_SCAN:   if (scan_done) state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b1;
    accept = 1'b0;
    issue  = 1'b0;
    decide = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      ST_SCAN:   issue  = !rd_last;
      ST_DECIDE: decide = 1'b1;
      default:   busy   = 1'b1;
    endcase
  end

  assign ctrl.clear = accept;
  assign ctrl.proc  = dv;

  // Capacity zero counts as one, and anything above the slot count as full.
  always_comb begin
    cap_eff = WW'(capacity_in_use);
    if (cap_eff == '0) begin
      cap_eff = WW'(1);
    end
    if (cap_eff > WW'(SLOTS)) begin
      cap_eff = WW'(SLOTS);
    end
    room = WW'(entries_used) < cap_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      capacity_in_use <= CAP_RESET;
      rd_last         <= 1'b0;
      dv              <= 1'b0;
      valid           <= '0;
      entries_used    <= '0;
      pend_on         <= 1'b0;
      done            <= 1'b0;
    end else begin
      state <= state_next;
      dv    <= issue;
      done  <= decide;
      if (cfg_we) begin
        capacity_in_use <= cfg_data;
      end
      if (accept) begin
        rd_last <= 1'b0;
      end else if (issue && (rd_idx == IW'(SLOTS - 1))) begin
        rd_last <= 1'b1;
      end
      if (decide) begin
        pend_on <= 1'b1;
        if (!stat.found && room) begin
          valid[free_idx] <= 1'b1;
          entries_used    <= entries_used + LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_idx <= '0;
      req_x  <= tile_x;
      req_y  <= tile_y;
    end else if (issue) begin
      rd_idx <= rd_idx + IW'(1);
    end
    if (issue) begin
      di <= rd_idx;
    end
    if (decide) begin
      pend_x <= req_x;
      pend_y <= req_y;
      if (stat.found) begin
        hit        <= 1'b1;
        slot       <= hit_idx;
        evicted    <= 1'b0;
        evicted_x  <= '0;
        evicted_y  <= '0;
        pend_slot  <= hit_idx;
        pend_limit <= {1'b0, hit_rank};
      end else if (room) begin
        hit        <= 1'b0;
        slot       <= free_idx;
        evicted    <= 1'b0;
        evicted_x  <= '0;
        evicted_y  <= '0;
        pend_slot  <= free_idx;
        pend_limit <= LW'(SLOTS);
      end else begin
        hit        <= 1'b0;
        slot       <= lru_idx;
        evicted    <= 1'b1;
        evicted_x  <= lru_x;
        evicted_y  <= lru_y;
        pend_slot  <= lru_idx;
        pend_limit <= LW'(SLOTS);
      end
    end
  end

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the LRU tile cache lookup block.
module tb;
  import ltc_pkg::*;

  localparam int NUM_SLOTS = SLOTS_DEF;
  localparam int XW = COORD_BITS_DEF;
  localparam int SW = $clog2(NUM_SLOTS);
  localparam int LOOKUP_CYCLES = NUM_SLOTS + 3;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic          hit;
    logic [SW-1:0] slot;
    logic          evicted;
    logic [XW-1:0] evicted_x;
    logic [XW-1:0] evicted_y;
  } tile_result_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [XW-1:0]       tile_x = '0;
  logic [XW-1:0]       tile_y = '0;
  logic                cfg_we = 1'b0;
  logic [CAP_BITS-1:0] cfg_data = '0;
  logic                busy;
  logic                done;
  logic                hit;
  logic [SW-1:0]       slot;
  logic                evicted;
  logic [XW-1:0]       evicted_x;
  logic [XW-1:0]       evicted_y;

  // Shadow copy of the tag store and its recency order.
  logic [XW-1:0]       shadow_x [NUM_SLOTS];
  logic [XW-1:0]       shadow_y [NUM_SLOTS];
  bit                  shadow_valid [NUM_SLOTS];
  int                  shadow_rank [NUM_SLOTS];
  int                  shadow_used;
  logic [CAP_BITS-1:0] shadow_capacity;

  tile_result_t        pending_results[$];
  int                  sender_idle_pct;
  int                  fail_count;
  int                  lookups_sent;
  int                  hits_seen;
  int                  evictions_seen;
  int                  stall_cycles;
  logic [XW-1:0]       hot_x [32];
  logic [XW-1:0]       hot_y [32];
  int                  hot_count;

  lru_tile_cache_lookup dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .tile_x    (tile_x),
    .tile_y    (tile_y),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .done      (done),
    .hit       (hit),
    .slot      (slot),
    .evicted   (evicted),
    .evicted_x (evicted_x),
    .evicted_y (evicted_y)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ages every valid entry younger than limit and makes slot s the newest.
  function automatic void make_newest(input int s, input int limit);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (i != s && shadow_valid[i] && shadow_rank[i] < limit) shadow_rank[i]++;
    end
    shadow_rank[s] = 0;
  endfunction

  function automatic tile_result_t lookup_tile(input logic [XW-1:0] x, input logic [XW-1:0] y);
    tile_result_t r;
    int           s;
    int           cap;
    int           oldest;
    bit           found;
    bit           any;
    r = '{hit: 1'b0, slot: '0, evicted: 1'b0, evicted_x: '0, evicted_y: '0};
    s = 0;
    found = 1'b0;
    any = 1'b0;
    oldest = 0;
    cap = int'(shadow_capacity);
    if (cap == 0) cap = 1;
    if (cap > NUM_SLOTS) cap = NUM_SLOTS;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!found && shadow_valid[i] && shadow_x[i] == x && shadow_y[i] == y) begin
        s = i;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      make_newest(s, shadow_rank[s]);
    end else begin
      if (shadow_used < cap) begin
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
          if (!shadow_valid[i]) s = i;
        end
        shadow_used++;
      end else begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (shadow_valid[i] && (!any || shadow_rank[i] > oldest)) begin
            oldest = shadow_rank[i];
            s = i;
            any = 1'b1;
          end
        end
        r.evicted = 1'b1;
        r.evicted_x = shadow_x[s];
        r.evicted_y = shadow_y[s];
      end
      make_newest(s, NUM_SLOTS);
      shadow_valid[s] = 1'b1;
      shadow_x[s] = x;
      shadow_y[s] = y;
    end
    r.slot = s[SW-1:0];
    return r;
  endfunction

  // Leaves start high on return, so back-to-back items need no extra edge.
  task automatic send_lookup(input logic [XW-1:0] x, input logic [XW-1:0] y);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
    end
    start <= 1'b1;
    tile_x <= x;
    tile_y <= y;
    do @(posedge clk); while (busy);
    pending_results.push_back(lookup_tile(x, y));
    lookups_sent++;
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] value);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_capacity = value;
  endtask

  always @(posedge clk) begin
    tile_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no lookup pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.hit) hits_seen++;
        if (want.evicted) evictions_seen++;
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          fail_count++;
        end
        if (slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, slot);
          fail_count++;
        end
        if (evicted !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, evicted);
          fail_count++;
        end
        if (evicted_x !== want.evicted_x) begin
          $error("evicted_x: expected %h, got %h", want.evicted_x, evicted_x);
          fail_count++;
        end
        if (evicted_y !== want.evicted_y) begin
          $error("evicted_y: expected %h, got %h", want.evicted_y, evicted_y);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Corner coordinates, hits, and tiles that share one coordinate only.
  task automatic test_hit_and_fill();
    send_lookup(16'h0000, 16'h0000);
    send_lookup(16'hFFFF, 16'hFFFF);
    send_lookup(16'h0000, 16'h0000);
    send_lookup(16'hFFFF, 16'h0000);
    send_lookup(16'h0000, 16'hFFFF);
    send_lookup(16'hFFFF, 16'hFFFF);
    send_lookup(16'h0000, 16'h0001);
    send_lookup(16'h0001, 16'h0000);
    send_lookup(16'h8000, 16'h8000);
  endtask

  // Capacity below the entries in use, zero, above the slot count, and one.
  task automatic test_capacity_extremes();
    write_capacity(5'd2);
    send_lookup(16'h1234, 16'h5678);
    send_lookup(16'h1234, 16'h5678);
    send_lookup(16'hABCD, 16'hEF01);
    write_capacity(5'd0);
    send_lookup(16'h5555, 16'hAAAA);
    send_lookup(16'h5555, 16'hAAAA);
    write_capacity(5'd31);
    send_lookup(16'hAAAA, 16'h5555);
    send_lookup(16'h0000, 16'h0000);
    write_capacity(5'd1);
    send_lookup(16'hFFFE, 16'h0001);
    write_capacity(5'd16);
    send_lookup(16'h7FFF, 16'h7FFF);
  endtask

  // Mostly a small hot set of tiles so that hits and evictions both occur,
  // mixed with fully random coordinates.
  task automatic test_random_lookups(input int idle_pct);
    int pick;
    sender_idle_pct = idle_pct;
    for (int chunk = 0; chunk < 5; chunk++) begin
      case ($urandom_range(5))
        0: write_capacity(5'd1);
        1: write_capacity(5'd16);
        2: write_capacity(5'd0);
        3: write_capacity(5'd31);
        4: write_capacity(5'($urandom_range(2, 15)));
        default: write_capacity(5'($urandom_range(17, 30)));
      endcase
      hot_count = $urandom_range(2, 24);
      for (int i = 0; i < hot_count; i++) begin
        hot_x[i] = XW'($urandom);
        hot_y[i] = XW'($urandom);
      end
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(99) < 70) begin
          pick = int'($urandom_range(hot_count - 1));
          send_lookup(hot_x[pick], hot_y[pick]);
        end else begin
          send_lookup(XW'($urandom), XW'($urandom));
        end
      end
    end
  endtask

  initial begin
    sender_idle_pct = 15;
    fail_count = 0;
    lookups_sent = 0;
    hits_seen = 0;
    evictions_seen = 0;
    shadow_used = 0;
    shadow_capacity = CAP_RESET;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      shadow_x[i] = '0;
      shadow_y[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_hit_and_fill();
    test_capacity_extremes();
    test_random_lookups(15);
    test_random_lookups(67);
    test_random_lookups(0);
    wait_for_results();
    repeat (LOOKUP_CYCLES) @(posedge clk);
    $display("tb: %0d lookups checked, %0d hits and %0d evictions,", lookups_sent,
             hits_seen, evictions_seen);
    $display("tb: capacities from zero to 31 under three sender idle patterns.");
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
